### src/uitf_pkg.sv
// ----------------------------------------------------------------------------
// uitf_pkg
// types and constants shared by the uart idle-gap framer modules
// ----------------------------------------------------------------------------
package uitf_pkg;

  localparam int BYTE_W      = 8;
  localparam int TICK_W      = 8;
  localparam int OUT_SLOT_W  = 3;
  localparam int OUT_POS_W   = 5;
  // widest values over the whole parameter range
  localparam int SLOT_MAX_W  = 3;
  localparam int LEN_MAX_W   = 9;
  localparam int ADDR_MAX_W  = 11;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

  localparam int CMD_Q_DEPTH = 2;
  localparam int CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
  localparam int CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd0;
  localparam logic [TICK_W-1:0]    IDLE_TIMEOUT_RESET = 8'd5;
  localparam logic [TICK_W-1:0]    TICK_COUNT_MAX = 8'hFF;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
  } uitf_in_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] frame_slot;
    logic [BYTE_W-1:0]     data_byte;
    logic [OUT_POS_W-1:0]  byte_position;
    logic [OUT_POS_W-1:0]  frame_length;
    logic                  last;
  } uitf_out_t;

  // frame readout request from front to back
  typedef struct packed {
    logic [SLOT_MAX_W-1:0] slot;
    logic [ADDR_MAX_W-1:0] base;
    logic [LEN_MAX_W-1:0]  len;
  } uitf_cmd_t;

  // slot released by the back once its last byte has been read
  typedef struct packed {
    logic                  valid;
    logic [SLOT_MAX_W-1:0] slot;
  } uitf_rel_t;

endpackage

### src/uitf_ram.sv
// ----------------------------------------------------------------------------
// uitf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module uitf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 57
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/uitf_cmd_q.sv
// ----------------------------------------------------------------------------
// uitf_cmd_q
// short fifo of frame readout requests between front and back
// ----------------------------------------------------------------------------
module uitf_cmd_q
  import uitf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  uitf_cmd_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output uitf_cmd_t pop_data
);

  uitf_cmd_t              entry_r [CMD_Q_DEPTH];
  logic [CMD_Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_Q_CNT_W-1:0] count_r, count_nxt;
  logic                   push, pop;

  assign push_ready = (count_r != CMD_Q_CNT_W'(CMD_Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/uitf_front.sv
// ----------------------------------------------------------------------------
// uitf_front
// takes bytes and ticks, stores bytes into the open slot, closes frames on
// idle timeout and queues them for readout
// ----------------------------------------------------------------------------
module uitf_front
  import uitf_pkg::*;
#(
  parameter int SLOT_COUNT      = 3,
  parameter int MAX_FRAME_BYTES = 19,
  localparam int DEPTH  = SLOT_COUNT * MAX_FRAME_BYTES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uitf_in_t          in_data,
  input  logic [TICK_W-1:0] idle_timeout,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output uitf_cmd_t         cmd,
  input  uitf_rel_t         rel
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);

  logic                  receiving_r, receiving_nxt;
  logic [LEN_W-1:0]      open_len_r, open_len_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [TICK_W-1:0]     idle_r, idle_nxt;
  logic [SLOT_COUNT-1:0] busy_r, busy_nxt;

  logic              accept, is_byte, room, close;
  logic [LEN_W-1:0]  wr_pos;
  logic [TICK_W-1:0] idle_inc;

  assign is_byte  = (in_data.mode == MODE_BYTE);
  // a byte may not land in a slot whose previous frame is still being read
  assign in_ready = cmd_ready && !(is_byte && busy_r[slot_r]);
  assign accept   = in_valid && in_ready;

  assign wr_pos   = receiving_r ? open_len_r : '0;
  assign room     = !receiving_r || (open_len_r < LEN_W'(MAX_FRAME_BYTES));
  assign idle_inc = (idle_r == TICK_COUNT_MAX) ? idle_r : idle_r + 1'b1;
  assign close    = accept && !is_byte && receiving_r && (idle_inc >= idle_timeout);

  assign ram_we    = accept && is_byte && room;
  assign ram_waddr = base_r + ADDR_W'(wr_pos);
  assign ram_wdata = in_data.rx_byte;

  assign cmd_valid = close;
  assign cmd.slot  = SLOT_MAX_W'(slot_r);
  assign cmd.base  = ADDR_MAX_W'(base_r);
  assign cmd.len   = LEN_MAX_W'(open_len_r);

  always_comb begin
    receiving_nxt = receiving_r;
    open_len_nxt  = open_len_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    idle_nxt      = idle_r;
    busy_nxt      = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.slot[SLOT_W-1:0]] = 1'b0;
    end
    if (accept && is_byte) begin
      receiving_nxt = 1'b1;
      idle_nxt      = '0;
      if (room) begin
        open_len_nxt = wr_pos + 1'b1;
      end
    end else if (accept && receiving_r) begin
      idle_nxt = idle_inc;
      if (close) begin
        receiving_nxt    = 1'b0;
        busy_nxt[slot_r] = 1'b1;
        if (slot_r == SLOT_W'(SLOT_COUNT - 1)) begin
          slot_nxt = '0;
          base_nxt = '0;
        end else begin
          slot_nxt = slot_r + 1'b1;
          base_nxt = base_r + ADDR_W'(MAX_FRAME_BYTES);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      open_len_r  <= '0;
      slot_r      <= '0;
      base_r      <= '0;
      idle_r      <= '0;
      busy_r      <= '0;
    end else begin
      receiving_r <= receiving_nxt;
      open_len_r  <= open_len_nxt;
      slot_r      <= slot_nxt;
      base_r      <= base_nxt;
      idle_r      <= idle_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

### src/uitf_back.sv
// ----------------------------------------------------------------------------
// uitf_back
// reads a closed frame out of the byte store, one word per cycle unless the
// output stalls, through a read stage and an output register
// ----------------------------------------------------------------------------
module uitf_back
  import uitf_pkg::*;
#(
  parameter int SLOT_COUNT      = 3,
  parameter int MAX_FRAME_BYTES = 19,
  localparam int DEPTH  = SLOT_COUNT * MAX_FRAME_BYTES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  uitf_cmd_t         cmd,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output uitf_rel_t         rel,
  output logic              out_valid,
  input  logic              out_ready,
  output uitf_out_t         out_data
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_MAX_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic [LEN_W-1:0]      rd_pos_r, rd_pos_nxt;
  logic [LEN_W-1:0]      rd_len_r, rd_len_nxt;
  logic [SLOT_MAX_W-1:0] rd_slot_r, rd_slot_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  uitf_out_t             out_data_r, out_data_nxt;

  logic out_load, rd_free, issue, is_last;

  assign out_load  = rd_valid_r && (!out_valid_r || out_ready);
  assign rd_free   = !rd_valid_r || out_load;
  assign issue     = (state_r == ST_READ) && rd_free;
  assign is_last   = (pos_r == len_r - 1'b1);

  assign cmd_ready = (state_r == ST_IDLE);
  assign ram_re    = issue;
  assign ram_raddr = base_r + ADDR_W'(pos_r);
  assign rel.valid = issue && is_last;
  assign rel.slot  = slot_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    rd_valid_nxt  = rd_valid_r;
    rd_pos_nxt    = rd_pos_r;
    rd_len_nxt    = rd_len_r;
    rd_slot_nxt   = rd_slot_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = ST_READ;
          slot_nxt  = cmd.slot;
          base_nxt  = cmd.base[ADDR_W-1:0];
          len_nxt   = cmd.len[LEN_W-1:0];
          pos_nxt   = '0;
        end
      end
      ST_READ: begin
        if (issue) begin
          pos_nxt = pos_r + 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // read stage follows the ram's registered output
    if (issue) begin
      rd_valid_nxt = 1'b1;
      rd_pos_nxt   = pos_r;
      rd_len_nxt   = len_r;
      rd_slot_nxt  = slot_r;
      rd_last_nxt  = is_last;
    end else if (out_load) begin
      rd_valid_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.frame_slot    = OUT_SLOT_W'(rd_slot_r);
      out_data_nxt.data_byte     = ram_rdata;
      out_data_nxt.byte_position = OUT_POS_W'(rd_pos_r);
      out_data_nxt.frame_length  = OUT_POS_W'(rd_len_r);
      out_data_nxt.last          = rd_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    rd_pos_r   <= rd_pos_nxt;
    rd_len_r   <= rd_len_nxt;
    rd_slot_r  <= rd_slot_nxt;
    rd_last_r  <= rd_last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### src/uart_idle_timeout_framer.sv
// ----------------------------------------------------------------------------
// uart_idle_timeout_framer
// splits a received uart byte stream into frames at idle gaps
// ----------------------------------------------------------------------------
// in_ channel: one word per received byte (mode byte) or per timer tick
// (mode tick). bytes go into the open slot of a ring of SLOT_COUNT frame
// slots, up to MAX_FRAME_BYTES each; later bytes are dropped but still
// restart the idle count. once the idle count reaches the timeout register
// the frame closes and is queued for readout.
// out_ channel: one word per stored byte of a closed frame, with slot,
// position, length and a last flag on the final byte.
// throughput: the front takes one word per cycle. a closed frame passes through
// the request queue and the back, then drains one word per cycle through the
// byte store read port, the read stage and the output register.
// the front only waits when the request queue is full or a byte targets a
// slot that is still being read out.
// when out_ready is low the output register and read stage hold, readout
// pauses and the front keeps collecting bytes for the next slot.
// reset: synchronous, active low; idle, slot 0, timeout back to 5. the byte
// store needs no clearing.
// cfg_ port: register 0 at byte address 0 holds the idle timeout in ticks.
// ----------------------------------------------------------------------------
module uart_idle_timeout_framer
  import uitf_pkg::*;
#(
  parameter int SLOT_COUNT      = 3,
  parameter int MAX_FRAME_BYTES = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  uitf_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output uitf_out_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int DEPTH  = SLOT_COUNT * MAX_FRAME_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [TICK_W-1:0] timeout_r, timeout_nxt;
  logic              reg_hit, cfg_wr;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  uitf_cmd_t fq_cmd, qb_cmd;
  uitf_rel_t rel;

  // register file
  assign reg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_IDLE_TIMEOUT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? CFG_DATA_W'(timeout_r) : '0;
  assign timeout_nxt = (cfg_wr && reg_hit) ? cfg_pwdata[TICK_W-1:0] : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= IDLE_TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  uitf_front #(
    .SLOT_COUNT      (SLOT_COUNT),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .idle_timeout (timeout_r),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .cmd_valid    (fq_valid),
    .cmd_ready    (fq_ready),
    .cmd          (fq_cmd),
    .rel          (rel)
  );

  uitf_cmd_q u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_cmd)
  );

  uitf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  uitf_back #(
    .SLOT_COUNT      (SLOT_COUNT),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // readout words stay inside their frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_position < out_data.frame_length))
    else $error("byte position beyond frame length");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last ==
      (out_data.byte_position + 5'd1 == out_data.frame_length)))
    else $error("last flag not on final byte");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_slot < SLOT_COUNT))
    else $error("frame slot outside ring");

  // a release comes only while the queue head, if any, holds a non-empty request
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |-> (qb_cmd.len != '0 || !qb_valid))
    else $error("slot released with empty request");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the uart idle-gap framer
// ----------------------------------------------------------------------------
// received bytes and timer ticks are offered on the in_ channel with random
// gaps. every accepted word updates a framer model in the scoreboard, which
// queues the byte words that a closing tick must produce. words on the out_
// channel are compared field by field against that queue while the receiver
// stalls at random. the idle timeout register is rewritten between phases,
// covering zero, one and 255, and one phase backs the output up until the
// block stops taking input.
// ----------------------------------------------------------------------------
module tb
  import uitf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 3;
  localparam int FRAME_MAX = 19;
  localparam int SETTLE    = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 1'd1;

  class frame_scoreboard;
    logic [TICK_W-1:0] timeout_ticks;
    int unsigned       idle_ticks;
    bit                receiving;
    int unsigned       open_len;
    int unsigned       slot;
    logic [BYTE_W-1:0] frame_bytes [FRAME_MAX];
    uitf_out_t         expected_bytes [$];
    int unsigned       errors;

    function new();
      timeout_ticks = IDLE_TIMEOUT_RESET;
      idle_ticks    = 0;
      receiving     = 1'b0;
      open_len      = 0;
      slot          = 0;
      errors        = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_IDLE_TIMEOUT) begin
        timeout_ticks = value[TICK_W-1:0];
      end
    endfunction

    function void accept_word(uitf_in_t w);
      uitf_out_t r;
      if (w.mode == MODE_BYTE) begin
        if (!receiving) begin
          receiving = 1'b1;
          open_len  = 0;
        end
        // a full frame drops the byte but the idle count still restarts
        if (open_len < FRAME_MAX) begin
          frame_bytes[open_len] = w.rx_byte;
          open_len++;
        end
        idle_ticks = 0;
      end else if (receiving) begin
        if (idle_ticks < TICK_COUNT_MAX) idle_ticks++;
        if (idle_ticks >= timeout_ticks) begin
          receiving = 1'b0;
          for (int i = 0; i < open_len; i++) begin
            r.frame_slot    = slot[OUT_SLOT_W-1:0];
            r.data_byte     = frame_bytes[i];
            r.byte_position = i[OUT_POS_W-1:0];
            r.frame_length  = open_len[OUT_POS_W-1:0];
            r.last          = (i + 1 == open_len);
            expected_bytes.push_back(r);
          end
          slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
        end
      end
    endfunction

    function void check_byte(uitf_out_t got);
      uitf_out_t exp_w;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected word: slot %0d byte %h pos %0d len %0d last %b",
                   got.frame_slot, got.data_byte, got.byte_position,
                   got.frame_length, got.last);
        end
        return;
      end
      exp_w = expected_bytes.pop_front();
      if (got.frame_slot !== exp_w.frame_slot || got.data_byte !== exp_w.data_byte ||
          got.byte_position !== exp_w.byte_position ||
          got.frame_length !== exp_w.frame_length || got.last !== exp_w.last) begin
        errors++;
        if (errors <= 10) begin
          $display("word mismatch: expected slot %0d byte %h pos %0d len %0d last %b",
                   exp_w.frame_slot, exp_w.data_byte, exp_w.byte_position,
                   exp_w.frame_length, exp_w.last);
          $display("               got      slot %0d byte %h pos %0d len %0d last %b",
                   got.frame_slot, got.data_byte, got.byte_position,
                   got.frame_length, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  uitf_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  uitf_out_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  frame_scoreboard model = new();

  // receiver behaviour, steered by the main sequence
  int  stall_pct = 30;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  sender_gaps = 1'b1;

  uart_idle_timeout_framer #(
    .SLOT_COUNT      (SLOTS),
    .MAX_FRAME_BYTES (FRAME_MAX)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) model.accept_word(in_data);
    if (rst_n && out_valid && out_ready) model.check_byte(out_data);
  end

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = 400;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
    end
  end

  function automatic uitf_in_t make_word(logic mode, logic [BYTE_W-1:0] b);
    uitf_in_t w;
    w.mode    = mode;
    w.rx_byte = b;
    return w;
  endfunction

  task automatic send_word(input uitf_in_t w);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    send_word(make_word(MODE_TICK, BYTE_W'($urandom)));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_word(make_word(MODE_BYTE, b));
  endtask

  // waits for every queued word, then for the front to finish quiet words
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    model.set_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // bytes with short tick runs that stay under the timeout, then the close
  task automatic send_frame(input int nbytes, output int words);
    int k;
    int closing;
    words = 0;
    for (int i = 0; i < nbytes; i++) begin
      send_byte(BYTE_W'($urandom));
      words++;
      if (model.timeout_ticks > 1 && $urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, (model.timeout_ticks - 1 > 3) ? 3 : model.timeout_ticks - 1);
        repeat (k) send_tick();
        words += k;
      end
    end
    closing = (model.timeout_ticks == 0) ? 1 : model.timeout_ticks;
    repeat (closing) send_tick();
    words += closing;
    // tick while idle, ignored by the block
    if ($urandom_range(0, 3) == 0) send_tick();
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 85) return $urandom_range(7, 18);
    return $urandom_range(19, 24);
  endfunction

  task automatic run_phase(input int goal);
    int sent;
    int words;
    int n;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(0, 99) < 15) begin
        // broken sequence: bytes and ticks in any order
        n = $urandom_range(4, 10);
        repeat (n) send_word(make_word(1'($urandom_range(0, 1)), BYTE_W'($urandom)));
        sent += n;
      end else begin
        send_frame(pick_len(), words);
        sent += words;
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("FAIL uart_idle_timeout_framer");
    $finish;
  end

  initial begin
    int words;
    int goals [6];
    logic [TICK_W-1:0] timeouts [6];

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while idle, then a frame whose idle count is restarted by a byte
    send_tick();
    send_byte(8'h00);
    send_tick();
    send_tick();
    send_byte(8'hFF);
    repeat (5) send_tick();
    wait_idle();

    // zero timeout: the first tick after a byte closes the frame
    cfg_write(REG_IDLE_TIMEOUT, 32'h0);
    send_byte(8'h7E);
    send_tick();
    wait_idle();

    // write to an unused register index changes nothing
    cfg_write(REG_UNUSED, 32'h0000_0007);
    send_byte(8'h80);
    send_byte(8'h01);
    send_tick();
    wait_idle();

    // output held off long enough for the request queue to fill
    cfg_write(REG_IDLE_TIMEOUT, 32'h1);
    sender_gaps = 1'b0;
    stall_pct   = 0;
    hold_requests++;
    repeat (5) send_frame($urandom_range(2, 6), words);
    wait_idle();

    timeouts = '{8'd3, 8'd2, 8'd255, 8'd1, 8'd8, 8'd0};
    goals    = '{32, 32, 0, 32, 32, 32};
    timeouts[3] = TICK_W'($urandom_range(1, 6));
    for (int p = 0; p < 6; p++) begin
      cfg_write(REG_IDLE_TIMEOUT, {24'($urandom), timeouts[p]});
      sender_gaps = (p % 3 != 1);
      stall_pct   = (p % 3 == 1) ? 0 : $urandom_range(10, 50);
      if (timeouts[p] == 8'd255) begin
        // long timeout: the frame stays open until a shorter one is set
        send_byte(BYTE_W'($urandom));
        repeat (4) send_tick();
        send_byte(BYTE_W'($urandom));
      end else begin
        run_phase(goals[p]);
      end
      wait_idle();
    end

    if (model.errors == 0 && model.expected_bytes.size() == 0) begin
      $display("PASS uart_idle_timeout_framer");
    end else begin
      $display("FAIL uart_idle_timeout_framer");
    end
    $finish;
  end

endmodule

### uart_idle_timeout_framer.f
src/uitf_pkg.sv
src/uitf_ram.sv
src/uitf_cmd_q.sv
src/uitf_front.sv
src/uitf_back.sv
src/uart_idle_timeout_framer.sv
bench/tb.sv
